### rtl/assert_macros.svh
// Assertion macros for the RTL of the integer execute unit.
// Self-contained; included by any module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/rv32iex_pkg.sv
// Package of the RV32I integer execute unit: sizes, operation codes and the
// structs passed between its modules. Depends on nothing.
package rv32iex_pkg;

  localparam int XLEN      = 32;
  localparam int NUM_REGS  = 32;
  localparam int RegIdxW   = $clog2(NUM_REGS);
  localparam int RegNumW   = 5;
  localparam int ShamtW    = 5;
  localparam int InsnBytes = 4;
  localparam logic [XLEN-1:0] StartPcReset = '0;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADDI  = 5'd1,
    OP_SUB   = 5'd2,
    OP_LUI   = 5'd3,
    OP_XOR   = 5'd4,
    OP_XORI  = 5'd5,
    OP_OR    = 5'd6,
    OP_ORI   = 5'd7,
    OP_AND   = 5'd8,
    OP_ANDI  = 5'd9,
    OP_SLL   = 5'd10,
    OP_SRL   = 5'd11,
    OP_SRA   = 5'd12,
    OP_SLT   = 5'd13,
    OP_SLTI  = 5'd14,
    OP_SLTU  = 5'd15,
    OP_SLTIU = 5'd16,
    OP_BEQ   = 5'd17,
    OP_BNE   = 5'd18,
    OP_BLT   = 5'd19,
    OP_BLTU  = 5'd20,
    OP_BGE   = 5'd21,
    OP_BGEU  = 5'd22,
    OP_JAL   = 5'd23,
    OP_JALR  = 5'd24
  } op_t;

  // Register file write port.
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] addr;
    logic [XLEN-1:0]    data;
  } rf_wr_t;

  // Outcome of executing one instruction.
  typedef struct packed {
    logic [XLEN-1:0]    next_pc;
    logic               reg_write;
    logic [RegNumW-1:0] write_reg;
    logic [XLEN-1:0]    write_value;
    logic               branch_taken;
  } exec_res_t;

endpackage

### rtl/rv32i_integer_execute_unit.sv
// Top level of the RV32I integer execute unit: operand stage, execute logic,
// result register and program counter. Depends on rv32iex_pkg,
// rv32iex_regfile, rv32iex_exec and assert_macros.svh.
//
// The unit takes one decoded RV32I instruction per transaction on the input
// channel (mode, dest_reg, src_reg_a, src_reg_b, immediate) and returns one
// result transaction for each of them: the next program counter, the register
// write if any, and whether the flow of control was redirected. It holds a
// register file of NUM_REGS words and the program counter. One instruction is
// accepted every clock cycle as long as the output side keeps up. An accepted
// instruction passes the operand stage, then the result register. The operand
// stage reads both source operands from the register file, whose read port is
// registered; the execute step runs the ALU, branch compare and next-PC logic
// and loads the result register, committing the register write and the new PC
// at the same edge. A write made by the instruction ahead is forwarded to the
// operands of the one behind it, so back-to-back dependent instructions see each
// other's results. The result register parts the two channels: a new instruction
// still enters while an earlier result waits to be taken, and stall on the
// input rises only when the operand stage holds an instruction that cannot
// move on. Writing cfg_wdata with cfg_we loads the program counter at once;
// do so only while no transaction is in flight. Reset clears the register file
// to zero and the program counter to zero.

`include "assert_macros.svh"

module rv32i_integer_execute_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rv32iex_pkg::XLEN-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [4:0]                          mode,
  input  logic [rv32iex_pkg::RegNumW-1:0]     dest_reg,
  input  logic [rv32iex_pkg::RegNumW-1:0]     src_reg_a,
  input  logic [rv32iex_pkg::RegNumW-1:0]     src_reg_b,
  input  logic signed [rv32iex_pkg::XLEN-1:0] immediate,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rv32iex_pkg::XLEN-1:0]        next_pc,
  output logic                                reg_write,
  output logic [rv32iex_pkg::RegNumW-1:0]     write_reg,
  output logic [rv32iex_pkg::XLEN-1:0]        write_value,
  output logic                                branch_taken
);
  import rv32iex_pkg::*;

  // Operand stage: the accepted instruction waiting to execute.
  logic                ex_valid;
  op_t                 ex_op;
  logic [RegNumW-1:0]  ex_dest;
  logic [XLEN-1:0]     ex_imm;

  logic [XLEN-1:0]     pc;
  logic [XLEN-1:0]     src_a;
  logic [XLEN-1:0]     src_b;
  exec_res_t           res;
  rf_wr_t              rf_wr;

  logic                out_free;
  logic                ex_fire;
  logic                in_fire;

  // The result register can load when it is empty or being emptied now.
  assign out_free = !out_valid || !out_stall;
  assign ex_fire  = ex_valid && out_free;
  assign in_stall = ex_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_fire) begin
      ex_valid <= 1'b1;
    end else if (ex_fire) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_op   <= op_t'(mode);
      ex_dest <= dest_reg;
      ex_imm  <= $unsigned(immediate);
    end
  end

  // The register write and the PC update commit as the instruction leaves
  // the operand stage, so the next instruction always sees them.
  assign rf_wr.en   = ex_fire && res.reg_write;
  assign rf_wr.addr = res.write_reg[RegIdxW-1:0];
  assign rf_wr.data = res.write_value;

  rv32iex_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_fire),
    .rd_addr_a (src_reg_a),
    .rd_addr_b (src_reg_b),
    .wr        (rf_wr),
    .rd_data_a (src_a),
    .rd_data_b (src_b)
  );

  rv32iex_exec u_exec (
    .op       (ex_op),
    .dest_reg (ex_dest),
    .src_a    (src_a),
    .src_b    (src_b),
    .imm      (ex_imm),
    .pc       (pc),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= StartPcReset;
    end else if (cfg_we) begin
      pc <= cfg_wdata;
    end else if (ex_fire) begin
      pc <= res.next_pc;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= ex_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      next_pc      <= res.next_pc;
      reg_write    <= res.reg_write;
      write_reg    <= res.write_reg;
      write_value  <= res.write_value;
      branch_taken <= res.branch_taken;
    end
  end

  // A delivered write never names register zero.
  `ASSERT_ALWAYS(a_no_write_r0, clk, rst, !(out_valid && reg_write) || (write_reg != '0))

  // A result without a register write carries zero register and value.
  `ASSERT_ALWAYS(a_idle_write_zero, clk, rst,
                 !(out_valid && !reg_write) || (write_reg == '0 && write_value == '0))

  // After an instruction executes, the PC matches the next_pc it reports.
  `ASSERT_NEXT(a_pc_commit, clk, rst, ex_fire && !cfg_we, out_valid && (pc == next_pc))

endmodule

### rtl/rv32iex_regfile.sv
// Register file of the integer execute unit: two registered read ports with
// write bypass, one write port, per-entry valid bits. Depends on rv32iex_pkg.
module rv32iex_regfile (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rd_en,
  input  logic [rv32iex_pkg::RegNumW-1:0]      rd_addr_a,
  input  logic [rv32iex_pkg::RegNumW-1:0]      rd_addr_b,
  input  rv32iex_pkg::rf_wr_t                  wr,
  output logic [rv32iex_pkg::XLEN-1:0]         rd_data_a,
  output logic [rv32iex_pkg::XLEN-1:0]         rd_data_b
);
  import rv32iex_pkg::*;

  logic [XLEN-1:0]     mem [NUM_REGS];
  logic [NUM_REGS-1:0] entry_valid;

  logic [XLEN-1:0]     mem_q_a;
  logic [XLEN-1:0]     mem_q_b;
  logic                live_a;
  logic                live_b;
  logic                byp_a;
  logic                byp_b;
  logic [XLEN-1:0]     byp_data;

  logic [RegIdxW-1:0]  idx_a;
  logic [RegIdxW-1:0]  idx_b;
  logic                ok_a;
  logic                ok_b;

  assign idx_a = rd_addr_a[RegIdxW-1:0];
  assign idx_b = rd_addr_b[RegIdxW-1:0];
  // Register zero and numbers beyond the file read as zero.
  assign ok_a = (rd_addr_a != '0) && (6'(rd_addr_a) < 6'(NUM_REGS));
  assign ok_b = (rd_addr_b != '0) && (6'(rd_addr_b) < 6'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr.en) begin
      entry_valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_a  <= mem[idx_a];
      mem_q_b  <= mem[idx_b];
      live_a   <= ok_a && entry_valid[idx_a];
      live_b   <= ok_b && entry_valid[idx_b];
      // A write landing at the same edge is not yet in the array.
      byp_a    <= ok_a && wr.en && (wr.addr == idx_a);
      byp_b    <= ok_b && wr.en && (wr.addr == idx_b);
      byp_data <= wr.data;
    end
  end

  assign rd_data_a = byp_a ? byp_data : (live_a ? mem_q_a : '0);
  assign rd_data_b = byp_b ? byp_data : (live_b ? mem_q_b : '0);

endmodule

### rtl/rv32iex_exec.sv
// Combinational execute logic: ALU, branch compare and next-PC selection for
// one instruction. Depends on rv32iex_pkg.
module rv32iex_exec (
  input  rv32iex_pkg::op_t                 op,
  input  logic [rv32iex_pkg::RegNumW-1:0]  dest_reg,
  input  logic [rv32iex_pkg::XLEN-1:0]     src_a,
  input  logic [rv32iex_pkg::XLEN-1:0]     src_b,
  input  logic [rv32iex_pkg::XLEN-1:0]     imm,
  input  logic [rv32iex_pkg::XLEN-1:0]     pc,
  output rv32iex_pkg::exec_res_t           res
);
  import rv32iex_pkg::*;

  logic [XLEN-1:0]   seq_pc;
  logic [XLEN-1:0]   target;
  logic [XLEN-1:0]   jalr_target;
  logic [ShamtW-1:0] shamt;
  logic              lt_s;
  logic              lt_u;
  logic              eq;
  logic [XLEN-1:0]   val;
  logic              wr;
  logic              taken;
  logic              dest_ok;

  assign seq_pc      = pc + XLEN'(InsnBytes);
  assign target      = pc + imm;
  assign jalr_target = (src_a + imm) & ~XLEN'(1);
  assign shamt       = src_b[ShamtW-1:0];
  assign lt_s        = $signed(src_a) < $signed(src_b);
  assign lt_u        = src_a < src_b;
  assign eq          = src_a == src_b;
  assign dest_ok     = (dest_reg != '0) && (6'(dest_reg) < 6'(NUM_REGS));

  always_comb begin
    val   = '0;
    wr    = 1'b0;
    taken = 1'b0;
    unique case (op) inside
      OP_ADD:   begin val = src_a + src_b;  wr = 1'b1; end
      OP_ADDI:  begin val = src_a + imm;    wr = 1'b1; end
      OP_SUB:   begin val = src_a - src_b;  wr = 1'b1; end
      OP_LUI:   begin val = imm;            wr = 1'b1; end
      OP_XOR:   begin val = src_a ^ src_b;  wr = 1'b1; end
      OP_XORI:  begin val = src_a ^ imm;    wr = 1'b1; end
      OP_OR:    begin val = src_a | src_b;  wr = 1'b1; end
      OP_ORI:   begin val = src_a | imm;    wr = 1'b1; end
      OP_AND:   begin val = src_a & src_b;  wr = 1'b1; end
      OP_ANDI:  begin val = src_a & imm;    wr = 1'b1; end
      OP_SLL:   begin val = src_a << shamt; wr = 1'b1; end
      OP_SRL:   begin val = src_a >> shamt; wr = 1'b1; end
      OP_SRA:   begin val = XLEN'($signed(src_a) >>> shamt); wr = 1'b1; end
      OP_SLT:   begin val = XLEN'(lt_s); wr = 1'b1; end
      OP_SLTI:  begin val = XLEN'($signed(src_a) < $signed(imm)); wr = 1'b1; end
      OP_SLTU:  begin val = XLEN'(lt_u); wr = 1'b1; end
      OP_SLTIU: begin val = XLEN'(src_a < imm); wr = 1'b1; end
      OP_BEQ:   taken = eq;
      OP_BNE:   taken = !eq;
      OP_BLT:   taken = lt_s;
      OP_BLTU:  taken = lt_u;
      OP_BGE:   taken = !lt_s;
      OP_BGEU:  taken = !lt_u;
      OP_JAL, OP_JALR: begin
        val   = seq_pc;
        wr    = 1'b1;
        taken = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.reg_write    = wr && dest_ok;
    res.write_reg    = res.reg_write ? dest_reg : '0;
    res.write_value  = res.reg_write ? val : '0;
    res.branch_taken = taken;
    if (op == OP_JALR) begin
      res.next_pc = jalr_target;
    end else if (taken) begin
      res.next_pc = target;
    end else begin
      res.next_pc = seq_pc;
    end
  end

endmodule
